// ----- rtl/csaw_pkg.sv -----
// shared types, codes and widths for the complete-set arbitrage walk
`timescale 1ns / 1ps

package csaw_pkg;

   // field widths
   localparam int OP_W          = 2;
   localparam int OUTCOME_W     = 3;
   localparam int PRICE_W       = 16;
   localparam int CONTRACTS_W   = 32;
   localparam int SET_COST_W    = 19;
   localparam int STATUS_W      = 2;
   localparam int PAYOUT_W      = 20;
   localparam int OCNT_W        = 4;
   localparam int CSR_IDX_W     = 1;
   localparam int CSR_DATA_W    = 20;

   // parameter defaults
   localparam int DEF_MAX_OUTCOMES = 8;
   localparam int DEF_MAX_LEVELS   = 8;

   // register reset values
   localparam logic [PAYOUT_W-1:0] PAYOUT_RESET = 20'd100;
   localparam logic [OCNT_W-1:0]   OCNT_RESET   = 4'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PAYOUT   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTCOMES = 1'd1;

   // operation codes
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
   localparam logic [OP_W-1:0] OP_DETECT = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_LEVEL   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NONE    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;
   localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic                use_req;      // book counters indexed by the request outcome
      logic                clear_books;
      logic                append;
      logic                set_status;
      logic [STATUS_W-1:0] status_code;
      logic                idx_clear;
      logic                idx_inc;
      logic                mem_rd;
      logic                rd_next;      // read level after the cursor, else level zero
      logic                load_init;
      logic                load_next;
      logic                sum_clear;
      logic                sum_acc;
      logic                upd_sub;
      logic                exh_clear;
      logic                pend_clear;
      logic                pend_load;
      logic                push_pend;
      logic                push_last;
      logic                push_rpt;
   } csaw_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic payout_zero;
      logic few_outcomes;
      logic drop;
      logic count_zero;
      logic idx_last;
      logic cost_below;
      logic rem_zero;
      logic level_more;
      logic exhausted;
      logic pend_valid;
      logic out_free;
   } csaw_sts_type;

endpackage

// ----- rtl/csaw_datapath.sv -----
// datapath: config registers, book storage, cursors, sums and result register
`timescale 1ns / 1ps

module csaw_datapath import csaw_pkg::*; #(
   parameter int MAX_OUTCOMES = DEF_MAX_OUTCOMES,
   parameter int MAX_LEVELS   = DEF_MAX_LEVELS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic [OUTCOME_W-1:0]   req_outcome,
   input  logic [PRICE_W-1:0]     req_ask_price,
   input  logic [CONTRACTS_W-1:0] req_ask_contracts,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [SET_COST_W-1:0]  rsp_set_cost,
   output logic [CONTRACTS_W-1:0] rsp_set_quantity,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic                   rsp_last,
   input  csaw_cmd_type           cmd,
   output csaw_sts_type           sts
);

   localparam int OW    = $clog2(MAX_OUTCOMES);
   localparam int NW    = $clog2(MAX_OUTCOMES + 1);
   localparam int LW    = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int CW    = $clog2(MAX_LEVELS + 1) > 0 ? $clog2(MAX_LEVELS + 1) : 1;
   localparam int DEPTH = MAX_OUTCOMES * MAX_LEVELS;
   localparam int AW    = $clog2(DEPTH);
   localparam int SW    = PRICE_W + OW;
   localparam int CMPW  = (SW > PAYOUT_W) ? SW : PAYOUT_W;

   // config
   logic [PAYOUT_W-1:0] payout_ff;
   logic [OCNT_W-1:0]   ocnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         payout_ff <= PAYOUT_RESET;
         ocnt_ff   <= OCNT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PAYOUT:   payout_ff <= PAYOUT_W'(csr_wdata);
            CSR_OUTCOMES: ocnt_ff   <= OCNT_W'(csr_wdata);
            default: ;
         endcase
      end
   end

   logic [NW-1:0] n_eff;
   assign n_eff = (32'(ocnt_ff) > MAX_OUTCOMES) ? NW'(MAX_OUTCOMES) : NW'(ocnt_ff);

   // level storage
   logic [PRICE_W-1:0]     mem_price [DEPTH];
   logic [CONTRACTS_W-1:0] mem_cont  [DEPTH];
   logic [PRICE_W-1:0]     rd_price_ff;
   logic [CONTRACTS_W-1:0] rd_cont_ff;

   // per-outcome book state
   logic [CW-1:0]          level_count_ff [MAX_OUTCOMES];
   logic [LW-1:0]          pos_ff         [MAX_OUTCOMES];
   logic [PRICE_W-1:0]     cur_price_ff   [MAX_OUTCOMES];
   logic [CONTRACTS_W-1:0] cur_rem_ff     [MAX_OUTCOMES];

   logic [OW-1:0] idx_ff, idx_in;
   logic [OW-1:0] oidx;
   logic [OW-1:0] cnt_idx;
   logic [CW-1:0] cnt_sel;
   logic          oob;
   logic          drop;
   logic [AW-1:0] waddr, raddr;
   logic [LW-1:0] rd_level;

   assign oidx    = OW'(req_outcome);
   assign oob     = !(32'(req_outcome) < MAX_OUTCOMES);
   assign cnt_idx = cmd.use_req ? oidx : idx_ff;
   assign cnt_sel = level_count_ff[cnt_idx];
   assign drop    = oob || (req_ask_contracts == '0) || (cnt_sel >= CW'(MAX_LEVELS));

   assign waddr    = AW'(oidx) * AW'(MAX_LEVELS) + AW'(cnt_sel);
   assign rd_level = cmd.rd_next ? LW'(pos_ff[idx_ff] + 1'b1) : '0;
   assign raddr    = AW'(idx_ff) * AW'(MAX_LEVELS) + AW'(rd_level);

   always_ff @(posedge clock) begin
      if (cmd.append && !drop) begin
         mem_price[waddr] <= req_ask_price;
         mem_cont[waddr]  <= req_ask_contracts;
      end
      if (cmd.mem_rd) begin
         rd_price_ff <= mem_price[raddr];
         rd_cont_ff  <= mem_cont[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_OUTCOMES; i++) level_count_ff[i] <= '0;
      end else if (cmd.clear_books) begin
         for (int i = 0; i < MAX_OUTCOMES; i++) level_count_ff[i] <= '0;
      end else if (cmd.append && !drop) begin
         level_count_ff[oidx] <= cnt_sel + 1'b1;
      end
   end

   // walk index
   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clear) idx_in = '0;
      else if (cmd.idx_inc) idx_in = idx_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) idx_ff <= '0;
      else idx_ff <= idx_in;
   end

   // cursors
   logic [CONTRACTS_W-1:0] least_ff;
   logic                   rem_zero;
   logic                   level_more;

   assign rem_zero   = (cur_rem_ff[idx_ff] == least_ff);
   assign level_more = (CW'(pos_ff[idx_ff]) + 1'b1) < cnt_sel;

   always_ff @(posedge clock) begin
      if (cmd.load_init) begin
         pos_ff[idx_ff]       <= '0;
         cur_price_ff[idx_ff] <= rd_price_ff;
         cur_rem_ff[idx_ff]   <= rd_cont_ff;
      end else if (cmd.load_next) begin
         pos_ff[idx_ff]       <= pos_ff[idx_ff] + 1'b1;
         cur_price_ff[idx_ff] <= rd_price_ff;
         cur_rem_ff[idx_ff]   <= rd_cont_ff;
      end else if (cmd.upd_sub) begin
         cur_rem_ff[idx_ff]   <= cur_rem_ff[idx_ff] - least_ff;
      end
   end

   // combined cost and smallest quantity of one step
   logic [SW-1:0] cost_ff;

   always_ff @(posedge clock) begin
      if (cmd.sum_clear) begin
         cost_ff  <= '0;
         least_ff <= '1;
      end else if (cmd.sum_acc) begin
         cost_ff <= cost_ff + SW'(cur_price_ff[idx_ff]);
         if (cur_rem_ff[idx_ff] < least_ff) least_ff <= cur_rem_ff[idx_ff];
      end
   end

   logic cost_below;
   assign cost_below = CMPW'(cost_ff) < CMPW'(payout_ff);

   // book ran out during this update pass
   logic exh_ff;

   always_ff @(posedge clock) begin
      if (reset) exh_ff <= 1'b0;
      else if (cmd.exh_clear) exh_ff <= 1'b0;
      else if (cmd.upd_sub && rem_zero && !level_more) exh_ff <= 1'b1;
   end

   // pending level, held back until we know whether it is the last one
   logic                   pend_valid_ff;
   logic [SET_COST_W-1:0]  pend_cost_ff;
   logic [CONTRACTS_W-1:0] pend_qty_ff;
   logic [STATUS_W-1:0]    rpt_status_ff;

   always_ff @(posedge clock) begin
      if (reset) pend_valid_ff <= 1'b0;
      else if (cmd.pend_clear) pend_valid_ff <= 1'b0;
      else if (cmd.pend_load) pend_valid_ff <= 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.pend_load) begin
         pend_cost_ff <= SET_COST_W'(cost_ff);
         pend_qty_ff  <= least_ff;
      end
      if (cmd.set_status) rpt_status_ff <= cmd.status_code;
   end

   // result register
   logic                   rsp_valid_ff;
   logic [SET_COST_W-1:0]  rsp_cost_ff;
   logic [CONTRACTS_W-1:0] rsp_qty_ff;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic                   rsp_last_ff;
   logic                   out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.push_pend || cmd.push_rpt) rsp_valid_ff <= 1'b1;
      else if (!rsp_stall) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.push_pend) begin
         rsp_cost_ff   <= pend_cost_ff;
         rsp_qty_ff    <= pend_qty_ff;
         rsp_status_ff <= ST_LEVEL;
         rsp_last_ff   <= cmd.push_last;
      end else if (cmd.push_rpt) begin
         rsp_cost_ff   <= '0;
         rsp_qty_ff    <= '0;
         rsp_status_ff <= rpt_status_ff;
         rsp_last_ff   <= 1'b1;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_set_cost     = rsp_cost_ff;
   assign rsp_set_quantity = rsp_qty_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_last         = rsp_last_ff;

   always_comb begin
      sts.payout_zero  = (payout_ff == '0);
      sts.few_outcomes = (n_eff < NW'(2));
      sts.drop         = drop;
      sts.count_zero   = (cnt_sel == '0);
      sts.idx_last     = ((NW'(idx_ff) + NW'(1)) == n_eff);
      sts.cost_below   = cost_below;
      sts.rem_zero     = rem_zero;
      sts.level_more   = level_more;
      sts.exhausted    = exh_ff;
      sts.pend_valid   = pend_valid_ff;
      sts.out_free     = out_free;
   end

   // a beat is only loaded when the result register can take it
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.push_pend || cmd.push_rpt) |-> out_free)
      else $error("result loaded while register busy");

   // walk reads stay inside the active outcomes
   a_rd_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_rd |-> (NW'(idx_ff) < n_eff))
      else $error("level read beyond active outcomes");

   // only levels priced below the payout become results
   a_pend_below: assert property (@(posedge clock) disable iff (reset)
      cmd.pend_load |-> cost_below)
      else $error("level kept at or above payout");

   // a pending level is never dropped without being pushed
   a_pend_kept: assert property (@(posedge clock) disable iff (reset)
      (cmd.pend_load && pend_valid_ff) |-> cmd.push_pend)
      else $error("pending level overwritten");

endmodule

// ----- rtl/csaw_ctrl.sv -----
// controller state machine sequencing loads, reports and the book walk
`timescale 1ns / 1ps

module csaw_ctrl import csaw_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [OP_W-1:0] req_op,
   input  csaw_sts_type    sts,
   output csaw_cmd_type    cmd
);

   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_REPORT   = 9'b000000010,
      S_INIT_CHK = 9'b000000100,
      S_INIT_LD  = 9'b000001000,
      S_SUM      = 9'b000010000,
      S_DECIDE   = 9'b000100000,
      S_UPD      = 9'b001000000,
      S_UPD_LD   = 9'b010000000,
      S_FINISH   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.use_req = 1'b1;
            if (req_valid) begin
               unique case (req_op)
                  OP_CLEAR: cmd.clear_books = 1'b1;
                  OP_APPEND: begin
                     cmd.append = 1'b1;
                     if (sts.drop) begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = ST_DROPPED;
                        state_in        = S_REPORT;
                     end
                  end
                  OP_DETECT: begin
                     if (sts.payout_zero) begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = ST_INVALID;
                        state_in        = S_REPORT;
                     end else if (sts.few_outcomes) begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = ST_NONE;
                        state_in        = S_REPORT;
                     end else begin
                        cmd.idx_clear  = 1'b1;
                        cmd.pend_clear = 1'b1;
                        cmd.exh_clear  = 1'b1;
                        state_in       = S_INIT_CHK;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_REPORT: begin
            if (sts.out_free) begin
               cmd.push_rpt = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_INIT_CHK: begin
            if (sts.count_zero) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = ST_NONE;
               state_in        = S_REPORT;
            end else begin
               cmd.mem_rd = 1'b1;
               state_in   = S_INIT_LD;
            end
         end
         S_INIT_LD: begin
            cmd.load_init = 1'b1;
            if (sts.idx_last) begin
               cmd.idx_clear = 1'b1;
               cmd.sum_clear = 1'b1;
               state_in      = S_SUM;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_INIT_CHK;
            end
         end
         S_SUM: begin
            cmd.sum_acc = 1'b1;
            if (sts.idx_last) state_in = S_DECIDE;
            else cmd.idx_inc = 1'b1;
         end
         S_DECIDE: begin
            if (sts.cost_below) begin
               if (!sts.pend_valid || sts.out_free) begin
                  cmd.push_pend = sts.pend_valid;
                  cmd.pend_load = 1'b1;
                  cmd.idx_clear = 1'b1;
                  state_in      = S_UPD;
               end
            end else begin
               cmd.set_status  = 1'b1;
               cmd.status_code = ST_NONE;
               state_in        = S_FINISH;
            end
         end
         S_UPD: begin
            cmd.upd_sub = 1'b1;
            if (sts.rem_zero && sts.level_more) begin
               cmd.mem_rd  = 1'b1;
               cmd.rd_next = 1'b1;
               state_in    = S_UPD_LD;
            end else if (sts.idx_last) begin
               if (sts.exhausted || sts.rem_zero) begin
                  state_in = S_FINISH;
               end else begin
                  cmd.idx_clear = 1'b1;
                  cmd.sum_clear = 1'b1;
                  state_in      = S_SUM;
               end
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_UPD_LD: begin
            cmd.load_next = 1'b1;
            if (sts.idx_last) begin
               if (sts.exhausted) begin
                  state_in = S_FINISH;
               end else begin
                  cmd.idx_clear = 1'b1;
                  cmd.sum_clear = 1'b1;
                  state_in      = S_SUM;
               end
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_UPD;
            end
         end
         S_FINISH: begin
            if (sts.out_free) begin
               cmd.push_pend = sts.pend_valid;
               cmd.push_last = 1'b1;
               cmd.push_rpt  = !sts.pend_valid;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // requests are only taken with the walk at rest
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> (state_ff == S_IDLE))
      else $error("request accepted outside idle");

   // a refill on the last outcome leaves the update pass for a new sum or the end
   a_upd_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPD_LD && sts.idx_last) |=>
      (state_ff == S_SUM || state_ff == S_FINISH))
      else $error("update pass ended in wrong state");

   // the finishing beat carries last
   a_finish_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && cmd.push_pend) |-> cmd.push_last)
      else $error("final level beat without last");

endmodule

// ----- rtl/complete_set_arbitrage_walk.sv -----
// top level of the complete-set arbitrage walk over per-outcome ask books
`timescale 1ns / 1ps

// Holds one ask book per outcome (up to MAX_LEVELS levels each, loaded best
// price first) and, on a detect beat, walks the first outcome_count books
// together, giving one result beat per combined ask level priced below the
// payout, with last set on the final one; a detect with no such level, a
// zero payout or fewer than two outcomes gives one status beat instead. A
// clear or append beat is taken while idle and leaves the block ready for
// the next beat; a dropped append gives one status beat. A detection first
// loads the cursors outcome by outcome, then per emitted level sums prices
// across outcomes, decides and updates the cursors; a book refill needs one
// registered read of the single level memory read port. Beats wait while
// rsp_stall is high; the walk holds one level back so it can flag last.
module complete_set_arbitrage_walk import csaw_pkg::*; #(
   parameter int MAX_OUTCOMES = DEF_MAX_OUTCOMES,
   parameter int MAX_LEVELS   = DEF_MAX_LEVELS
) (
   input  logic                   clock,
   input  logic                   reset,
   // configuration writes
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   // request beats
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [OP_W-1:0]        req_op,
   input  logic [OUTCOME_W-1:0]   req_outcome,
   input  logic [PRICE_W-1:0]     req_ask_price,
   input  logic [CONTRACTS_W-1:0] req_ask_contracts,
   // result beats
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [SET_COST_W-1:0]  rsp_set_cost,
   output logic [CONTRACTS_W-1:0] rsp_set_quantity,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic                   rsp_last
);

   csaw_cmd_type cmd;
   csaw_sts_type sts;

   // sequencing of loads, reports and walk steps
   csaw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (req_op),
      .sts       (sts),
      .cmd       (cmd)
   );

   // books, cursors, cost sum and result register
   csaw_datapath #(
      .MAX_OUTCOMES (MAX_OUTCOMES),
      .MAX_LEVELS   (MAX_LEVELS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_outcome       (req_outcome),
      .req_ask_price     (req_ask_price),
      .req_ask_contracts (req_ask_contracts),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_set_cost      (rsp_set_cost),
      .rsp_set_quantity  (rsp_set_quantity),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last),
      .cmd               (cmd),
      .sts               (sts)
   );

endmodule
